@@ hdl/tdc_pkg.sv @@
// ----------------------------------------------------------------------------
// tdc_pkg: shared types and constants for the time-of-day counter
// Time record, request and settings structs, and the decimal digit split.
// ----------------------------------------------------------------------------
package tdc_pkg;

  // Command codes carried in the request tuser bit
  localparam logic CMD_TICK = 1'b0;
  localparam logic CMD_LOAD = 1'b1;

  // Settings register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_CLOCK_FORMAT    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COUNTING_ENABLE = 2'd1;

  // Hour format codes
  localparam logic FMT_12H = 1'b0;
  localparam logic FMT_24H = 1'b1;

  // Counter limits
  localparam logic [5:0] SEC_WRAP       = 6'd60;
  localparam logic [5:0] MIN_WRAP       = 6'd60;
  localparam logic [5:0] HOUR_NOON      = 6'd12;
  localparam logic [5:0] HOUR_WRAP_12   = 6'd13;
  localparam logic [5:0] HOUR_WRAP_24   = 6'd24;
  localparam logic [4:0] MAX_LOAD_HOUR  = 5'd23;
  localparam logic [5:0] MAX_LOAD_MNSC  = 6'd59;

  // Packed widths of the streams
  localparam int unsigned IN_DATA_W  = 24;
  localparam int unsigned OUT_DATA_W = 40;

  // Time held by the counter
  typedef struct packed {
    logic       pm;
    logic [4:0] hr;
    logic [5:0] mn;
    logic [5:0] sc;
  } tod_t;

  // One registered request
  typedef struct packed {
    logic       cmd;
    logic       load_afternoon;
    logic [5:0] load_seconds;
    logic [5:0] load_minutes;
    logic [4:0] load_hours;
  } tdc_item_t;

  // Settings registers
  typedef struct packed {
    logic clock_format;
    logic counting_enabled;
  } tdc_cfg_t;

  // Decimal digits of a value below 60
  typedef struct packed {
    logic [2:0] tens;
    logic [3:0] units;
  } digits_t;

  // Split a value of 0..59 into tens and units by compare ladder
  function automatic digits_t split_digits(input logic [5:0] v);
    digits_t    d;
    logic [5:0] base;
    d.tens = 3'd0;
    base   = 6'd0;
    if (v >= 6'd50) begin
      d.tens = 3'd5;
      base   = 6'd50;
    end else if (v >= 6'd40) begin
      d.tens = 3'd4;
      base   = 6'd40;
    end else if (v >= 6'd30) begin
      d.tens = 3'd3;
      base   = 6'd30;
    end else if (v >= 6'd20) begin
      d.tens = 3'd2;
      base   = 6'd20;
    end else if (v >= 6'd10) begin
      d.tens = 3'd1;
      base   = 6'd10;
    end
    d.units = 4'(v - base);
    return d;
  endfunction

endpackage

@@ hdl/time_of_day_counter_12_24h.sv @@
// ----------------------------------------------------------------------------
// time_of_day_counter_12_24h: BCD-friendly real-time clock counter
// Seconds/minutes/hours with AM/PM, 12- or 24-hour format, load command.
// ----------------------------------------------------------------------------
// Each request is a one-second tick (tuser = 0) or a load (tuser = 1) and
// produces exactly one result: the time after the request plus its six
// decimal digits. A request is registered on entry; the new time and its
// digits are worked out from the input register and held in the result
// register. A new request is taken every cycle while results are taken.
// The time register is updated as each request leaves the input register,
// so back-to-back requests see each other's effect. Settings (format,
// counting enable) are written through the cfg channel, which is always
// ready, and should only change while idle. Load values above range are
// clamped to 23 h / 59 min / 59 s; the stored hour is not converted when
// the format changes.
// ----------------------------------------------------------------------------
module time_of_day_counter_12_24h (
  input  logic                               clk,
  input  logic                               rst,
  // Request stream
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // [4:0] load_hours, [10:5] load_minutes, [16:11] load_seconds,
  // [17] load_afternoon, [23:18] zero
  input  logic [tdc_pkg::IN_DATA_W-1:0]      s_axis_tdata,
  // [0] command
  input  logic                               s_axis_tuser,
  // Result stream
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // [5:0] seconds, [11:6] minutes, [16:12] hours, [17] afternoon,
  // [20:18] second_tens, [24:21] second_units, [27:25] minute_tens,
  // [31:28] minute_units, [33:32] hour_tens, [37:34] hour_units, [39:38] zero
  output logic [tdc_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
  // Settings write channel
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [tdc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic                               cfg_data
);

  logic                 in_valid;
  tdc_pkg::tdc_item_t   in_item;
  logic                 advance;
  tdc_pkg::tdc_cfg_t    cfg;
  tdc_pkg::tod_t        tod;
  tdc_pkg::tod_t        tod_next;
  tdc_pkg::digits_t     sec_dig;
  tdc_pkg::digits_t     min_dig;
  tdc_pkg::digits_t     hr_dig;

  // Handshake: input stage moves on when the result register is free
  assign advance       = in_valid && (!m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;
  assign cfg_ready     = 1'b1;

  // Settings registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.clock_format     <= tdc_pkg::FMT_24H;
      cfg.counting_enabled <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        tdc_pkg::REG_CLOCK_FORMAT:    cfg.clock_format     <= cfg_data;
        tdc_pkg::REG_COUNTING_ENABLE: cfg.counting_enabled <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_item.cmd            <= s_axis_tuser;
      in_item.load_hours     <= s_axis_tdata[4:0];
      in_item.load_minutes   <= s_axis_tdata[10:5];
      in_item.load_seconds   <= s_axis_tdata[16:11];
      in_item.load_afternoon <= s_axis_tdata[17];
    end
  end

  // Next-time logic
  tdc_advance u_advance (
    .cur  (tod),
    .item (in_item),
    .cfg  (cfg),
    .nxt  (tod_next)
  );

  // Time register
  always_ff @(posedge clk) begin
    if (rst) begin
      tod <= '0;
    end else if (advance) begin
      tod <= tod_next;
    end
  end

  // Decimal digits of the new time
  assign sec_dig = tdc_pkg::split_digits(tod_next.sc);
  assign min_dig = tdc_pkg::split_digits(tod_next.mn);
  assign hr_dig  = tdc_pkg::split_digits({1'b0, tod_next.hr});

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (advance) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      m_axis_tdata <= {2'b00,
                       hr_dig.units, hr_dig.tens[1:0],
                       min_dig.units, min_dig.tens,
                       sec_dig.units, sec_dig.tens,
                       tod_next.pm, tod_next.hr, tod_next.mn, tod_next.sc};
    end
  end

  // Checks
  a_time_in_range: assert property (@(posedge clk) disable iff (rst)
    (tod.sc < tdc_pkg::SEC_WRAP) && (tod.mn < tdc_pkg::MIN_WRAP) &&
    ({1'b0, tod.hr} < tdc_pkg::HOUR_WRAP_24))
    else $error("time register out of range");

  a_sec_digits: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |->
      ({3'd0, m_axis_tdata[20:18]} * 6'd10 + {2'd0, m_axis_tdata[24:21]}
       == m_axis_tdata[5:0]))
    else $error("second digits do not match seconds");

  a_result_matches_time: assert property (@(posedge clk) disable iff (rst)
    advance |=> (m_axis_tdata[17:0] == tod))
    else $error("result does not match time register");

  a_hold_when_idle: assert property (@(posedge clk) disable iff (rst)
    !advance |=> (tod == $past(tod)))
    else $error("time changed without a request");

endmodule

@@ hdl/tdc_advance.sv @@
// ----------------------------------------------------------------------------
// tdc_advance: next-time logic
// Applies a load or a one-second tick to the current time, with the
// seconds/minutes/hours carry chain and the AM/PM handling for both formats.
// ----------------------------------------------------------------------------
module tdc_advance (
  input  tdc_pkg::tod_t      cur,
  input  tdc_pkg::tdc_item_t item,
  input  tdc_pkg::tdc_cfg_t  cfg,
  output tdc_pkg::tod_t      nxt
);

  logic [5:0]    sec_inc;
  logic [5:0]    min_inc;
  logic [5:0]    hr_inc;
  tdc_pkg::tod_t ticked;
  tdc_pkg::tod_t loaded;

  // Increments of each field
  assign sec_inc = cur.sc + 6'd1;
  assign min_inc = cur.mn + 6'd1;
  assign hr_inc  = {1'b0, cur.hr} + 6'd1;

  // Tick: cascade carries
  always_comb begin
    ticked = cur;
    if (sec_inc >= tdc_pkg::SEC_WRAP) begin
      ticked.sc = 6'd0;
      if (min_inc >= tdc_pkg::MIN_WRAP) begin
        ticked.mn = 6'd0;
        ticked.hr = hr_inc[4:0];
        if (cfg.clock_format == tdc_pkg::FMT_12H) begin
          if (hr_inc == tdc_pkg::HOUR_NOON) begin
            ticked.pm = ~cur.pm;
          end else if (hr_inc >= tdc_pkg::HOUR_WRAP_12) begin
            ticked.hr = 5'd1;
          end
        end else begin
          if (hr_inc == tdc_pkg::HOUR_NOON) begin
            ticked.pm = 1'b1;
          end else if (hr_inc >= tdc_pkg::HOUR_WRAP_24) begin
            ticked.pm = 1'b0;
            ticked.hr = 5'd0;
          end
        end
      end else begin
        ticked.mn = min_inc;
      end
    end else begin
      ticked.sc = sec_inc;
    end
  end

  // Load: clamp values above range
  always_comb begin
    loaded.hr = (item.load_hours > tdc_pkg::MAX_LOAD_HOUR) ? tdc_pkg::MAX_LOAD_HOUR
                                                           : item.load_hours;
    loaded.mn = (item.load_minutes > tdc_pkg::MAX_LOAD_MNSC) ? tdc_pkg::MAX_LOAD_MNSC
                                                             : item.load_minutes;
    loaded.sc = (item.load_seconds > tdc_pkg::MAX_LOAD_MNSC) ? tdc_pkg::MAX_LOAD_MNSC
                                                             : item.load_seconds;
    loaded.pm = item.load_afternoon;
  end

  // Select by command; ticks are ignored while counting is frozen
  always_comb begin
    case (item.cmd)
      tdc_pkg::CMD_LOAD: nxt = loaded;
      tdc_pkg::CMD_TICK: nxt = cfg.counting_enabled ? ticked : cur;
      default:           nxt = cur;
    endcase
  end

endmodule

@@ tb/tod_result_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tod_result_checker: time predictor and result checker for the TOD counter
// Watches the request, result and settings channels, keeps its own copy of
// the clock and the settings, and checks every result field by field.
// ----------------------------------------------------------------------------
module tod_result_checker (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_axis_tvalid,
  input  logic                           s_axis_tready,
  input  logic [tdc_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  input  logic                           s_axis_tuser,
  input  logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  input  logic [tdc_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic [tdc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic                           cfg_data,
  output int                             mismatches,
  output int                             outstanding
);

  localparam int MAX_PRINTED    = 40;
  localparam int READING_FIELDS = 11;  // ten fields plus the zero fill

  tdc_pkg::tod_t                  clock_now;
  tdc_pkg::tdc_cfg_t              settings;
  logic [tdc_pkg::OUT_DATA_W-1:0] expected_readings [$];
  int                             results_seen;

  initial begin
    mismatches   = 0;
    outstanding  = 0;
    results_seen = 0;
  end

  // One line per mismatch, printing capped so a dead block cannot flood the log
  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= MAX_PRINTED) $display("MISMATCH: %s", msg);
    if (mismatches == MAX_PRINTED) $display("MISMATCH: further mismatches counted only");
  endtask

  function automatic logic [7:0] reading_field(input logic [tdc_pkg::OUT_DATA_W-1:0] w,
                                               input int idx);
    case (idx)
      0:       return 8'(w[5:0]);
      1:       return 8'(w[11:6]);
      2:       return 8'(w[16:12]);
      3:       return 8'(w[17]);
      4:       return 8'(w[20:18]);
      5:       return 8'(w[24:21]);
      6:       return 8'(w[27:25]);
      7:       return 8'(w[31:28]);
      8:       return 8'(w[33:32]);
      9:       return 8'(w[37:34]);
      default: return 8'(w[39:38]);
    endcase
  endfunction

  function automatic string field_name(input int idx);
    case (idx)
      0:       return "seconds";
      1:       return "minutes";
      2:       return "hours";
      3:       return "afternoon";
      4:       return "second_tens";
      5:       return "second_units";
      6:       return "minute_tens";
      7:       return "minute_units";
      8:       return "hour_tens";
      9:       return "hour_units";
      default: return "zero fill";
    endcase
  endfunction

  // Packed result word for a given time, digits split by plain division
  function automatic logic [tdc_pkg::OUT_DATA_W-1:0] reading_of(input tdc_pkg::tod_t t);
    return {2'b00, 4'(t.hr % 10), 2'(t.hr / 10), 4'(t.mn % 10), 3'(t.mn / 10),
            4'(t.sc % 10), 3'(t.sc / 10), t.pm, t.hr, t.mn, t.sc};
  endfunction

  // Advance the predicted clock by one request
  task automatic apply_request(input logic cmd, input logic [tdc_pkg::IN_DATA_W-1:0] d);
    logic [5:0] hr_next;
    if (cmd == tdc_pkg::CMD_LOAD) begin
      // out-of-range load values clamp, the period flag loads as given
      clock_now.hr = (d[4:0] > tdc_pkg::MAX_LOAD_HOUR) ? tdc_pkg::MAX_LOAD_HOUR : d[4:0];
      clock_now.mn = (d[10:5] > tdc_pkg::MAX_LOAD_MNSC) ? tdc_pkg::MAX_LOAD_MNSC : d[10:5];
      clock_now.sc = (d[16:11] > tdc_pkg::MAX_LOAD_MNSC) ? tdc_pkg::MAX_LOAD_MNSC
                                                         : d[16:11];
      clock_now.pm = d[17];
    end else if (settings.counting_enabled) begin
      if (clock_now.sc != tdc_pkg::SEC_WRAP - 6'd1) begin
        clock_now.sc = clock_now.sc + 6'd1;
      end else begin
        clock_now.sc = 6'd0;
        if (clock_now.mn != tdc_pkg::MIN_WRAP - 6'd1) begin
          clock_now.mn = clock_now.mn + 6'd1;
        end else begin
          clock_now.mn = 6'd0;
          hr_next      = {1'b0, clock_now.hr} + 6'd1;
          if (settings.clock_format == tdc_pkg::FMT_12H) begin
            // noon flips the period; anything past 12 wraps to 1, flag kept
            if (hr_next == tdc_pkg::HOUR_NOON) clock_now.pm = ~clock_now.pm;
            else if (hr_next >= tdc_pkg::HOUR_WRAP_12) hr_next = 6'd1;
          end else begin
            if (hr_next == tdc_pkg::HOUR_NOON) begin
              clock_now.pm = 1'b1;
            end else if (hr_next >= tdc_pkg::HOUR_WRAP_24) begin
              clock_now.pm = 1'b0;
              hr_next      = 6'd0;
            end
          end
          clock_now.hr = hr_next[4:0];
        end
      end
    end
  endtask

  task automatic check_reading(input logic [tdc_pkg::OUT_DATA_W-1:0] got);
    logic [tdc_pkg::OUT_DATA_W-1:0] want;
    if (expected_readings.size() == 0) begin
      report_mismatch($sformatf("result %0d arrived with nothing expected", results_seen));
    end else begin
      want = expected_readings.pop_front();
      for (int f = 0; f < READING_FIELDS; f++) begin
        if (reading_field(got, f) !== reading_field(want, f))
          report_mismatch($sformatf("result %0d: %s is %0d, expected %0d", results_seen,
                                    field_name(f), reading_field(got, f),
                                    reading_field(want, f)));
      end
    end
    results_seen++;
  endtask

  // Sample all channels on the rising edge
  always @(posedge clk) begin
    if (rst) begin
      clock_now                 = '0;
      settings.clock_format     = tdc_pkg::FMT_24H;
      settings.counting_enabled = 1'b1;
      expected_readings.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          tdc_pkg::REG_CLOCK_FORMAT:    settings.clock_format     = cfg_data;
          tdc_pkg::REG_COUNTING_ENABLE: settings.counting_enabled = cfg_data;
          default: ;
        endcase
      end
      if (m_axis_tvalid && m_axis_tready) check_reading(m_axis_tdata);
      if (s_axis_tvalid && s_axis_tready) begin
        apply_request(s_axis_tuser, s_axis_tdata);
        expected_readings.push_back(reading_of(clock_now));
      end
    end
    outstanding = expected_readings.size();
  end

endmodule

@@ tb/tb_time_of_day_counter_12_24h.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_time_of_day_counter_12_24h: testbench top for the time-of-day counter
// Drives ticks and loads with random gaps and result back-pressure, walks
// through both hour formats with counting on and frozen, and gives the
// verdict from the checker's mismatch count and its count of results still awaited.
// ----------------------------------------------------------------------------
module tb_time_of_day_counter_12_24h;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int RANDOM_PHASES = 10;
  localparam int PHASE_ITEMS   = 75;

  logic                           clk;
  logic                           rst;
  logic                           s_axis_tvalid;
  logic                           s_axis_tready;
  logic [tdc_pkg::IN_DATA_W-1:0]  s_axis_tdata;
  logic                           s_axis_tuser;
  logic                           m_axis_tvalid;
  logic                           m_axis_tready;
  logic [tdc_pkg::OUT_DATA_W-1:0] m_axis_tdata;
  logic                           cfg_valid;
  logic                           cfg_ready;
  logic [tdc_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic                           cfg_data;

  int mismatches;
  int outstanding;
  int cycle_count = 0;
  int loads_sent  = 0;
  int ticks_sent  = 0;
  bit no_idle     = 1'b0;

  time_of_day_counter_12_24h dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  tod_result_checker result_chk (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .mismatches    (mismatches),
    .outstanding   (outstanding)
  );

  // 10 ns clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results still awaited", cycle_count, outstanding);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    else if (roll < 92) return $urandom_range(1, 3);
    else return $urandom_range(6, 30);
  endfunction

  // Result side back-pressure
  initial begin
    int stall;
    m_axis_tready = 1'b0;
    @(negedge clk);
    forever begin
      stall = no_idle ? 0 : pick_gap();
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      m_axis_tready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(negedge clk);
    end
  end

  // Issue one request; valid stays high on return so back-to-back requests flow
  task automatic send_request(input logic cmd, input logic [4:0] hrs,
                              input logic [5:0] mins, input logic [5:0] secs,
                              input logic pm);
    int gap;
    gap = no_idle ? 0 : pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= {6'd0, pm, secs, mins, hrs};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk); while (!s_axis_tready);
    @(negedge clk);
    if (cmd == tdc_pkg::CMD_LOAD) loads_sent++;
    else ticks_sent++;
  endtask

  task automatic load_time(input logic [4:0] hrs, input logic [5:0] mins,
                           input logic [5:0] secs, input logic pm);
    send_request(tdc_pkg::CMD_LOAD, hrs, mins, secs, pm);
  endtask

  // A tick carries random load fields, which the block must ignore
  task automatic send_tick();
    send_request(tdc_pkg::CMD_TICK, 5'($urandom_range(0, 31)), 6'($urandom_range(0, 63)),
                 6'($urandom_range(0, 63)), 1'($urandom_range(0, 1)));
  endtask

  // Hold requests back until every result is in and the pipeline is empty
  task automatic wait_until_drained();
    s_axis_tvalid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_setting(input logic [tdc_pkg::CFG_IDX_W-1:0] idx, input logic val);
    cfg_index <= idx;
    cfg_data  <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  // Load close to a minute or hour rollover, hours biased to the boundaries
  task automatic load_near_rollover();
    logic [4:0] hrs;
    case ($urandom_range(0, 5))
      0:       hrs = 5'd11;
      1:       hrs = 5'd12;
      2:       hrs = 5'd23;
      3:       hrs = 5'($urandom_range(24, 31));
      default: hrs = 5'($urandom_range(0, 23));
    endcase
    load_time(hrs, ($urandom_range(0, 3) == 0) ? 6'($urandom_range(50, 58)) : 6'd59,
              6'($urandom_range(45, 59)), 1'($urandom_range(0, 1)));
  endtask

  // Stimulus
  initial begin
    int  roll;
    bit  fmt;
    bit  run_en;
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = tdc_pkg::CMD_TICK;
    cfg_valid     = 1'b0;
    cfg_index     = tdc_pkg::REG_CLOCK_FORMAT;
    cfg_data      = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: 24-hour format out of reset
    send_tick();
    load_time(5'd23, 6'd59, 6'd59, 1'b1);
    send_tick();                                // midnight wrap clears PM
    load_time(5'd11, 6'd59, 6'd59, 1'b0);
    send_tick();                                // noon sets PM
    load_time(5'd31, 6'd63, 6'd63, 1'b1);       // clamped load
    load_time(5'd0, 6'd0, 6'd0, 1'b0);
    load_time(5'd9, 6'd59, 6'd59, 1'b0);
    send_tick();                                // hour tens digit carry
    load_time(5'd15, 6'd0, 6'd0, 1'b0);         // period flag inconsistent
    send_tick();

    // directed: 12-hour format
    wait_until_drained();
    write_setting(tdc_pkg::REG_CLOCK_FORMAT, tdc_pkg::FMT_12H);
    load_time(5'd11, 6'd59, 6'd59, 1'b0);
    send_tick();                                // AM to PM at noon
    load_time(5'd11, 6'd59, 6'd59, 1'b1);
    send_tick();                                // PM to AM at midnight
    load_time(5'd12, 6'd59, 6'd59, 1'b1);
    send_tick();                                // 12 wraps to 1
    load_time(5'd23, 6'd59, 6'd59, 1'b0);
    send_tick();                                // out-of-format hour wraps to 1

    // directed: counting frozen, loads still land
    wait_until_drained();
    write_setting(tdc_pkg::REG_COUNTING_ENABLE, 1'b0);
    send_tick();
    load_time(5'd5, 6'd6, 6'd7, 1'b1);
    send_tick();

    // random phases, each with its own settings
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      wait_until_drained();
      fmt     = (phase == 0) ? tdc_pkg::FMT_24H : 1'($urandom_range(0, 1));
      run_en  = (phase == 0) ? 1'b1 : ($urandom_range(0, 5) != 0);
      no_idle = ($urandom_range(0, 3) == 0);
      write_setting(tdc_pkg::REG_CLOCK_FORMAT, fmt);
      write_setting(tdc_pkg::REG_COUNTING_ENABLE, run_en);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        // at times the sender holds off until the result stream has drained
        if ((phase == RANDOM_PHASES / 2 && k == PHASE_ITEMS / 2) || $urandom_range(0, 99) == 0)
          wait_until_drained();
        roll = $urandom_range(0, 99);
        if (roll < 12) load_near_rollover();
        else if (roll < 18)
          load_time(5'($urandom_range(0, 31)), 6'($urandom_range(0, 63)),
                    6'($urandom_range(0, 63)), 1'($urandom_range(0, 1)));
        else send_tick();
      end
    end

    // drain and settle
    wait_until_drained();
    repeat (6) @(negedge clk);
    $display("Covered %0d requests (%0d loads, %0d ticks) over %0d settings phases,",
             loads_sent + ticks_sent, loads_sent, ticks_sent, RANDOM_PHASES + 3);
    $display("both hour formats, counting running and frozen, clamped and boundary loads.");
    if (mismatches == 0 && outstanding == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
hdl/tdc_pkg.sv
hdl/tdc_advance.sv
hdl/time_of_day_counter_12_24h.sv
tb/tod_result_checker.sv
tb/tb_time_of_day_counter_12_24h.sv
